FILE: src/sobel_edge_threshold_assert.svh
// Assertion macros for the sobel_edge_threshold block.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH

`ifndef SYNTHESIS
// check that is held off while reset is asserted
`define SET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that holds at every edge, reset included
`define SET_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SET_ASSERT(lbl, clk, rst_n, prop, msg)
`define SET_ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

FILE: src/sobel_et_pkg.sv
// Shared constants and types of the Sobel edge threshold block.
// Used by the front, queue, back and top-level files; depends on nothing.
package sobel_et_pkg;

    localparam int PIX_W        = 8;
    localparam int DIM_W        = 12;
    localparam int THR_W        = 11;
    localparam int KSIZE        = 3;
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    // common width for counter against geometry compares
    localparam int GW           = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int SUM_W        = PIX_W + 2;
    localparam int SQ_W         = 2 * SUM_W;
    localparam int THR_SQ_W     = 2 * THR_W;
    localparam int Q_DEPTH      = 4;
    localparam int QCNT_W       = $clog2(Q_DEPTH + 1);
    localparam int QPTR_W       = $clog2(Q_DEPTH);
    localparam logic [PIX_W-1:0] EDGE_ON = {PIX_W{1'b1}};

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_geom;

    // one window ready for the gradient pipeline
    typedef struct packed {
        logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] pix;
        logic                                   mirror_l;
        logic                                   mirror_r;
        logic                                   top_refl;
        logic                                   frame_end;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

FILE: src/sobel_et_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the line buffers.
module sobel_et_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sobel_et_front.sv
// Front end: accepts words, tracks frame position, owns the line buffers and window.
// Depends on sobel_et_pkg, sobel_et_ram and the assertion macro header.
`include "sobel_edge_threshold_assert.svh"

module sobel_et_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [sobel_et_pkg::PIX_W-1:0] i_pixel,
    input  sobel_et_pkg::t_geom            i_geom,
    input  logic                           i_restart,
    input  sobel_et_pkg::t_q_stat          i_q_stat,
    output sobel_et_pkg::t_push            o_push
);
    import sobel_et_pkg::*;

    typedef struct packed {
        logic             valid;
        logic             is_virtual;
        logic             emit;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic             col_zero;
        logic             mirror_l;
        logic             top_refl;
        logic             frame_end;
    } t_slot;

    logic [COL_W-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic             r_draining, n_draining;
    t_slot            r_f1, n_f1;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] r_win, n_win, win_shift;

    logic [COL_W-1:0] f0_col, f0_ocol, c_icol, c_ocol;
    logic [ROW_W-1:0] f0_row, f0_orow, c_irow, c_orow;
    logic             f0_drain, f0_go, f0_emit, f0_last, c_drain, accept;
    logic [PIX_W-1:0] up_rd, mid_rd, f1_bot;
    logic             f1_we;

    // credit check: every in-flight window has a queue slot waiting for it
    assign o_ready = ({1'b0, i_q_stat.count} + (QCNT_W + 1)'(r_f1.valid && r_f1.emit))
                     < (QCNT_W + 1)'(Q_DEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        f0_col   = r_in_col;
        f0_row   = r_in_row;
        f0_ocol  = r_out_col;
        f0_orow  = r_out_row;
        f0_drain = r_draining;
        // a pixel during drain drops the old frame's tail
        if (!i_req_type && r_draining) begin
            f0_col   = '0;
            f0_row   = '0;
            f0_ocol  = '0;
            f0_orow  = '0;
            f0_drain = 1'b0;
        end
        f0_go   = i_req_type ? r_draining : 1'b1;
        f0_emit = i_req_type || (f0_row >= ROW_W'(2)) ||
                  ((f0_row == ROW_W'(1)) && (f0_col != '0));
        f0_last = (GW'(f0_orow) == GW'(i_geom.height) - GW'(1)) &&
                  (GW'(f0_ocol) == GW'(i_geom.width) - GW'(1));

        c_ocol = f0_ocol;
        c_orow = f0_orow;
        if (f0_emit) begin
            if (GW'(f0_ocol) + GW'(1) >= GW'(i_geom.width)) begin
                c_ocol = '0;
                c_orow = f0_orow + ROW_W'(1);
            end else begin
                c_ocol = f0_ocol + COL_W'(1);
            end
        end
        c_icol  = f0_col;
        c_irow  = f0_row;
        c_drain = f0_drain;
        if (f0_emit && f0_last) begin
            c_ocol  = '0;
            c_orow  = '0;
            c_icol  = '0;
            c_irow  = '0;
            c_drain = 1'b0;
        end
        if (i_req_type) begin
            if (c_drain) begin
                if (GW'(c_icol) + GW'(1) >= GW'(i_geom.width)) begin
                    c_icol = '0;
                end else begin
                    c_icol = c_icol + COL_W'(1);
                end
            end
        end else begin
            if (GW'(c_icol) + GW'(1) >= GW'(i_geom.width)) begin
                c_icol = '0;
                if (GW'(c_irow) + GW'(1) >= GW'(i_geom.height)) begin
                    c_irow  = '0;
                    c_drain = 1'b1;
                end else begin
                    c_irow = c_irow + ROW_W'(1);
                end
            end else begin
                c_icol = c_icol + COL_W'(1);
            end
        end

        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_draining = r_draining;
        n_f1            = r_f1;
        n_f1.valid      = 1'b0;
        n_f1.is_virtual = i_req_type;
        n_f1.emit       = f0_emit;
        n_f1.col        = f0_col;
        n_f1.pixel      = i_pixel;
        n_f1.col_zero   = (f0_col == '0);
        n_f1.mirror_l   = (f0_col == COL_W'(1));
        n_f1.top_refl   = (f0_orow == '0);
        n_f1.frame_end  = f0_last;
        if (i_restart) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_draining = 1'b0;
        end else if (accept && f0_go) begin
            n_in_col   = c_icol;
            n_in_row   = c_irow;
            n_out_col  = c_ocol;
            n_out_row  = c_orow;
            n_draining = c_drain;
            n_f1.valid = 1'b1;
        end
    end

    // second front stage: line buffer data is here, shift the window
    always_comb begin
        f1_bot = r_f1.is_virtual ? up_rd : r_f1.pixel;
        f1_we  = r_f1.valid && !r_f1.is_virtual;
        for (int r = 0; r < KSIZE; r++) begin
            win_shift[r][0] = r_win[r][1];
            win_shift[r][1] = r_win[r][2];
        end
        win_shift[0][2] = up_rd;
        win_shift[1][2] = mid_rd;
        win_shift[2][2] = f1_bot;
        n_win = r_f1.valid ? win_shift : r_win;

        o_push.valid         = r_f1.valid && r_f1.emit;
        // column zero closes the previous row on the window before the shift
        o_push.job.pix       = r_f1.col_zero ? r_win : win_shift;
        o_push.job.mirror_l  = r_f1.mirror_l;
        o_push.job.mirror_r  = r_f1.col_zero;
        o_push.job.top_refl  = r_f1.top_refl;
        o_push.job.frame_end = r_f1.frame_end;
    end

    sobel_et_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (f1_we),
        .i_waddr (r_f1.col),
        .i_wdata (mid_rd),
        .i_raddr (f0_col),
        .o_rdata (up_rd)
    );

    sobel_et_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (f1_we),
        .i_waddr (r_f1.col),
        .i_wdata (f1_bot),
        .i_raddr (f0_col),
        .o_rdata (mid_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_draining <= 1'b0;
            r_f1.valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_draining <= n_draining;
            r_f1       <= n_f1;
            r_win      <= n_win;
        end
    end

    `SET_ASSERT(a_in_col_range, i_clk, i_rst_n, GW'(r_in_col) < GW'(i_geom.width), "input column beyond row width")
    `SET_ASSERT(a_out_col_range, i_clk, i_rst_n, GW'(r_out_col) < GW'(i_geom.width), "output column beyond row width")
    `SET_ASSERT(a_drain_row, i_clk, i_rst_n, r_draining |-> (r_in_row == '0), "drain with input row not at frame start")

endmodule

FILE: src/sobel_et_queue.sv
// Short FIFO of windows between the front end and the gradient pipeline.
// Depends on sobel_et_pkg and the assertion macro header.
`include "sobel_edge_threshold_assert.svh"

module sobel_et_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sobel_et_pkg::t_push   i_push,
    output sobel_et_pkg::t_q_stat o_stat,
    output logic                  o_valid,
    output sobel_et_pkg::t_job    o_head,
    input  logic                  i_pop
);
    import sobel_et_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              pop;

    assign o_valid      = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign pop          = o_valid && i_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push.valid && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.valid && pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SET_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push.valid && (r_count == QCNT_W'(Q_DEPTH))), "window pushed into full queue")
    `SET_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= QCNT_W'(Q_DEPTH), "queue count beyond depth")
    `SET_ASSERT(a_head_hold, i_clk, i_rst_n, (o_valid && !i_pop) |=> $stable(o_head), "queue head changed while waiting")

endmodule

FILE: src/sobel_et_back.sv
// Back end: reflection, Sobel gradients, squared magnitude and threshold compare.
// Depends on sobel_et_pkg.
module sobel_et_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  sobel_et_pkg::t_job             i_job,
    output logic                           o_pop,
    input  logic [sobel_et_pkg::THR_W-1:0] i_threshold,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sobel_et_pkg::PIX_W-1:0] o_edge,
    output logic                           o_frame_end
);
    import sobel_et_pkg::*;

    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] p;
    logic [SUM_W-1:0]    gx_pos, gx_neg, gy_pos, gy_neg, n_abs_x, n_abs_y;
    logic                r_s1_valid, r_s1_last, r_s2_valid, r_s2_last;
    logic [SUM_W-1:0]    r_abs_x, r_abs_y;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y;
    logic [SQ_W:0]       mag;
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic                r_o_valid, r_o_last;
    logic [PIX_W-1:0]    r_o_edge;
    logic                rdy1, rdy2, rdy_o;

    assign rdy_o = !r_o_valid || i_ready;
    assign rdy2  = !r_s2_valid || rdy_o;
    assign rdy1  = !r_s1_valid || rdy2;
    assign o_pop = rdy1;

    always_comb begin
        p = i_job.pix;
        for (int r = 0; r < KSIZE; r++) begin
            if (i_job.mirror_l) begin
                p[r][0] = p[r][2];
            end
            if (i_job.mirror_r) begin
                p[r][2] = p[r][0];
            end
        end
        // first row of the frame: row above reflects to the row below
        if (i_job.top_refl) begin
            p[0] = p[2];
        end
        gx_pos = SUM_W'(p[0][2]) + {1'b0, p[1][2], 1'b0} + SUM_W'(p[2][2]);
        gx_neg = SUM_W'(p[0][0]) + {1'b0, p[1][0], 1'b0} + SUM_W'(p[2][0]);
        gy_pos = SUM_W'(p[2][0]) + {1'b0, p[2][1], 1'b0} + SUM_W'(p[2][2]);
        gy_neg = SUM_W'(p[0][0]) + {1'b0, p[0][1], 1'b0} + SUM_W'(p[0][2]);
        n_abs_x = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        n_abs_y = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    end

    assign mag = {1'b0, r_sq_x} + {1'b0, r_sq_y};

    always_ff @(posedge i_clk) begin
        r_thr_sq <= THR_SQ_W'(i_threshold) * THR_SQ_W'(i_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_q_valid;
                r_abs_x    <= n_abs_x;
                r_abs_y    <= n_abs_y;
                r_s1_last  <= i_job.frame_end;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
                r_sq_x     <= SQ_W'(r_abs_x) * SQ_W'(r_abs_x);
                r_sq_y     <= SQ_W'(r_abs_y) * SQ_W'(r_abs_y);
                r_s2_last  <= r_s1_last;
            end
            if (rdy_o) begin
                r_o_valid <= r_s2_valid;
                r_o_edge  <= (THR_SQ_W'(mag) > r_thr_sq) ? EDGE_ON : '0;
                r_o_last  <= r_s2_last;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_edge      = r_o_edge;
    assign o_frame_end = r_o_last;

endmodule

FILE: src/sobel_edge_threshold.sv
// Top level of the streaming 3x3 Sobel edge detector with magnitude threshold.
// Depends on sobel_et_pkg, sobel_et_front, sobel_et_queue and sobel_et_back.
//
// Takes 8-bit pixels in raster order, one word per clock, and returns 255 where
// gx*gx + gy*gy exceeds the threshold squared and 0 elsewhere, with reflect-101
// borders. The stream runs at one word per cycle sustained; input ready drops
// only under output backpressure, once the four-entry window queue has no slot
// left for the next window. Results trail the input by W+1 pixels, so after the
// last pixel of a frame send W+1 flush words (tuser high) to drain the last row;
// flush words outside that drain are taken and dropped. A pixel sent during the
// drain drops the old frame's tail. An emitting word's result passes through
// these registered steps in order: the line buffer read at the accepting edge,
// then the window shift into the queue, the gradient, the squaring and the
// compare. The two line buffers are 2048 x 8 RAMs left uninitialized after
// reset; no clearing pass is needed.
// Writing image_width or image_height restarts the frame position; write the
// registers only while the block is idle.
module sobel_edge_threshold (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sobel_et_pkg::PIX_W-1:0]  s_axis_tdata,  // [7:0] pixel_value
    input  logic                            s_axis_tuser,  // [0] req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sobel_et_pkg::PIX_W-1:0]  m_axis_tdata,  // [7:0] edge_value
    output logic                            m_axis_tlast,  // frame_end
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [sobel_et_pkg::DIM_W-1:0]  i_cfg_data
);
    import sobel_et_pkg::*;

    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;
    localparam int         MIN_DIM            = 3;
    localparam int         WIDTH_RESET        = 640;
    localparam int         HEIGHT_RESET       = 480;
    localparam int         THR_RESET          = 100;

    logic [DIM_W-1:0] r_image_width, n_image_width, r_image_height, n_image_height;
    logic [THR_W-1:0] r_edge_threshold, n_edge_threshold;
    logic [DIM_W-1:0] width_sat, height_sat;
    logic             restart;

    t_geom   geom;
    t_push   push;
    t_q_stat q_stat;
    t_job    head;
    logic    q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        width_sat  = i_cfg_data;
        height_sat = i_cfg_data;
        if (32'(i_cfg_data) < MIN_DIM) begin
            width_sat  = DIM_W'(MIN_DIM);
            height_sat = DIM_W'(MIN_DIM);
        end
        if (32'(i_cfg_data) > MAX_WIDTH) begin
            width_sat = DIM_W'(MAX_WIDTH);
        end
        if (32'(i_cfg_data) > HEIGHT_LIMIT) begin
            height_sat = DIM_W'(HEIGHT_LIMIT);
        end

        n_image_width    = r_image_width;
        n_image_height   = r_image_height;
        n_edge_threshold = r_edge_threshold;
        restart          = 1'b0;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_image_width = width_sat;
                    restart       = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_image_height = height_sat;
                    restart        = 1'b1;
                end
                CFG_EDGE_THRESHOLD: begin
                    n_edge_threshold = i_cfg_data[THR_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= DIM_W'(WIDTH_RESET);
            r_image_height   <= DIM_W'(HEIGHT_RESET);
            r_edge_threshold <= THR_W'(THR_RESET);
        end else begin
            r_image_width    <= n_image_width;
            r_image_height   <= n_image_height;
            r_edge_threshold <= n_edge_threshold;
        end
    end

    assign geom.width  = r_image_width;
    assign geom.height = r_image_height;

    sobel_et_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_pixel    (s_axis_tdata),
        .i_geom     (geom),
        .i_restart  (restart),
        .i_q_stat   (q_stat),
        .o_push     (push)
    );

    sobel_et_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (q_stat),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    sobel_et_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head),
        .o_pop       (q_pop),
        .i_threshold (r_edge_threshold),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_edge      (m_axis_tdata),
        .o_frame_end (m_axis_tlast)
    );

endmodule
